// ===== rtl/core/hsl_to_rgb_convert_defines.svh =====
// Assertion macros for the HSL to RGB converter.
// Included by modules that check their own pipeline; expects clk and arst_n in scope.
`ifndef HSL_TO_RGB_CONVERT_DEFINES_SVH
`define HSL_TO_RGB_CONVERT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define HSL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define HSL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/hsl_pkg.sv =====
// Shared constants for the HSL to RGB converter.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package hsl_pkg;

	// Fraction bits of the fixed-point format; ONE = 2**FRAC_BITS
	localparam int FRAC_BITS_DEF = 12;

	// Colour channel count and the index of each channel
	localparam int NUM_CH   = 3;
	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;

endpackage

`default_nettype wire

// ===== rtl/core/hsl_in_if.sv =====
// Valid/ready channel carrying one colour in hue, lightness, saturation form.
// Depends on hsl_pkg for the default fraction width.
`default_nettype none

interface hsl_in_if #(
	parameter int FRAC_BITS = hsl_pkg::FRAC_BITS_DEF
);
	logic                 valid;
	logic                 ready;
	logic [FRAC_BITS-1:0] hue;
	logic [FRAC_BITS:0]   lightness;
	logic [FRAC_BITS:0]   saturation;

	modport source (output valid, output hue, output lightness, output saturation,
		input ready);
	modport sink (input valid, input hue, input lightness, input saturation,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/core/hsl_out_if.sv =====
// Valid/ready channel carrying one colour as red, green and blue intensities.
// Depends on hsl_pkg for the default fraction width.
`default_nettype none

interface hsl_out_if #(
	parameter int FRAC_BITS = hsl_pkg::FRAC_BITS_DEF
);
	logic               valid;
	logic               ready;
	logic [FRAC_BITS:0] red;
	logic [FRAC_BITS:0] green;
	logic [FRAC_BITS:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/hsl_to_rgb_convert.sv =====
// HSL to RGB colour converter, six-stage fixed-point pipeline.
// Depends on hsl_pkg, hsl_in_if, hsl_out_if and hsl_to_rgb_convert_defines.svh.
`default_nettype none
`include "hsl_to_rgb_convert_defines.svh"

// Usage
//   hsl : sink channel; one transaction is one colour (hue Q0.F, lightness and
//         saturation Q1.F, values above 1.0 are clamped to 1.0).
//   rgb : source channel; one transaction per input colour, in order, with red,
//         green and blue in Q1.F, each within 0..1.0.
//   F = FRAC_BITS sets every field width (hue F bits, the rest F+1 bits).
// Timing
//   Six register stages (clamp, L*S product, m2, m1/slope, curve products, sum):
//   each colour passes through them in that order; rgb.valid is the sum stage's valid bit.
//   Throughput is one colour per cycle while rgb.ready is high; each stage holds one item.
// Reset
//   arst_n clears every stage valid bit at once; payload registers keep junk
//   that is never presented.
// Back-pressure
//   Each stage advances when it is empty or the stage after it advances, so a
//   stalled receiver freezes only the full tail of the pipeline; bubbles ahead
//   of it still close up and hsl.ready stays high until all six stages hold data.
//   Zero saturation needs no special path: the arithmetic yields grey directly.
module hsl_to_rgb_convert #(
	parameter int FRAC_BITS = hsl_pkg::FRAC_BITS_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	hsl_in_if.sink     hsl,
	hsl_out_if.source  rgb
);
	import hsl_pkg::*;

	localparam int ONE   = 1 << FRAC_BITS;
	localparam int THIRD = ONE / 3;
	localparam int W1    = FRAC_BITS + 1;  // holds 0..ONE
	localparam int W2    = FRAC_BITS + 2;  // holds 0..2*ONE
	localparam int W6    = FRAC_BITS + 3;  // holds 6*hue
	localparam int WP    = 2 * W1;         // full product width

	// Stage valid bits and advance enables
	logic [6:1] vld;
	logic [6:1] en;

	always_comb begin
		en[6] = !vld[6] || rgb.ready;
		for (int k = 5; k >= 1; k--) begin
			en[k] = !vld[k] || en[k+1];
		end
	end

	assign hsl.ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (en[1]) begin
				vld[1] <= hsl.valid;
			end
			for (int k = 2; k <= 6; k++) begin
				if (en[k]) begin
					vld[k] <= vld[k-1];
				end
			end
		end
	end

	// ---------------------------------------------------------------- stage 1
	// Clamp lightness and saturation, form the three hue sample positions
	logic [W1-1:0]        lig_c, sat_c;
	logic [FRAC_BITS-1:0] hpos_c [NUM_CH];
	logic [W1-1:0]        lig_s1, sat_s1;
	logic [FRAC_BITS-1:0] hpos_s1 [NUM_CH];

	always_comb begin
		lig_c = (hsl.lightness > W1'(ONE)) ? W1'(ONE) : hsl.lightness;
		sat_c = (hsl.saturation > W1'(ONE)) ? W1'(ONE) : hsl.saturation;
		hpos_c[CH_RED]   = hsl.hue + FRAC_BITS'(THIRD);
		hpos_c[CH_GREEN] = hsl.hue;
		hpos_c[CH_BLUE]  = hsl.hue + FRAC_BITS'(ONE - THIRD);
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			lig_s1  <= lig_c;
			sat_s1  <= sat_c;
			hpos_s1 <= hpos_c;
		end
	end

	// ---------------------------------------------------------------- stage 2
	// Truncated L*S product; pick each channel's curve factor in 0..ONE.
	// The flat top uses factor ONE (gives m2), the floor uses zero (gives m1).
	logic [WP-1:0] ls_full;
	logic [W6-1:0] h6_c   [NUM_CH];
	logic [W6-1:0] fall_c [NUM_CH];
	logic [W1-1:0] fac_c  [NUM_CH];
	logic [W1-1:0] lig_s2, sat_s2, prod_s2;
	logic [W1-1:0] fac_s2 [NUM_CH];

	assign ls_full = lig_s1 * sat_s1;

	always_comb begin
		for (int k = 0; k < NUM_CH; k++) begin
			h6_c[k]   = (W6'(hpos_s1[k]) << 2) + (W6'(hpos_s1[k]) << 1);
			fall_c[k] = W6'(4 * ONE) - h6_c[k];
			priority if (h6_c[k] < W6'(ONE)) begin
				fac_c[k] = h6_c[k][W1-1:0];
			end else if (h6_c[k] < W6'(3 * ONE)) begin
				fac_c[k] = W1'(ONE);
			end else if (h6_c[k] < W6'(4 * ONE)) begin
				fac_c[k] = fall_c[k][W1-1:0];
			end else begin
				fac_c[k] = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			lig_s2  <= lig_s1;
			sat_s2  <= sat_s1;
			prod_s2 <= ls_full[FRAC_BITS +: W1];
			fac_s2  <= fac_c;
		end
	end

	// ---------------------------------------------------------------- stage 3
	// m2, clamped to ONE and to 2L
	logic [W2-1:0] two_l_c, m2_sum, m2_lim, m2_c;
	logic [W1-1:0] m2_s3;
	logic [W2-1:0] two_l_s3;
	logic [W1-1:0] fac_s3 [NUM_CH];

	always_comb begin
		two_l_c = {lig_s2, 1'b0};
		if (two_l_c <= W2'(ONE)) begin
			m2_sum = W2'(lig_s2) + W2'(prod_s2);
		end else begin
			m2_sum = W2'(lig_s2) + W2'(sat_s2) - W2'(prod_s2);
		end
		m2_lim = (m2_sum > W2'(ONE)) ? W2'(ONE) : m2_sum;
		m2_c   = (m2_lim > two_l_c) ? two_l_c : m2_lim;
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			m2_s3    <= m2_c[W1-1:0];
			two_l_s3 <= two_l_c;
			fac_s3   <= fac_s2;
		end
	end

	// ---------------------------------------------------------------- stage 4
	// m1 = 2L - m2 and slope d = m2 - m1 = 2*m2 - 2L, both within 0..ONE
	logic [W2-1:0] m1_c, d_c;
	logic [W1-1:0] m1_s4, d_s4;
	logic [W1-1:0] fac_s4 [NUM_CH];

	assign m1_c = two_l_s3 - W2'(m2_s3);
	assign d_c  = {m2_s3, 1'b0} - two_l_s3;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			m1_s4  <= m1_c[W1-1:0];
			d_s4   <= d_c[W1-1:0];
			fac_s4 <= fac_s3;
		end
	end

	// ---------------------------------------------------------------- stage 5
	// One multiplier per channel: d * factor, truncated
	logic [WP-1:0] ramp_full [NUM_CH];
	logic [W1-1:0] m1_s5;
	logic [W1-1:0] ramp_s5 [NUM_CH];

	always_comb begin
		for (int k = 0; k < NUM_CH; k++) begin
			ramp_full[k] = d_s4 * fac_s4[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			m1_s5 <= m1_s4;
			for (int k = 0; k < NUM_CH; k++) begin
				ramp_s5[k] <= ramp_full[k][FRAC_BITS +: W1];
			end
		end
	end

	// ---------------------------------------------------------------- stage 6
	// Add the floor and saturate; this register also holds a stalled result
	logic [W2-1:0] chan_sum [NUM_CH];
	logic [W1-1:0] chan_c   [NUM_CH];
	logic [W1-1:0] chan_s6  [NUM_CH];

	always_comb begin
		for (int k = 0; k < NUM_CH; k++) begin
			chan_sum[k] = W2'(m1_s5) + W2'(ramp_s5[k]);
			chan_c[k]   = (chan_sum[k] > W2'(ONE)) ? W1'(ONE) : chan_sum[k][W1-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			chan_s6 <= chan_c;
		end
	end

	assign rgb.valid = vld[6];
	assign rgb.red   = chan_s6[CH_RED];
	assign rgb.green = chan_s6[CH_GREEN];
	assign rgb.blue  = chan_s6[CH_BLUE];

	// ------------------------------------------------------------- assertions
	`HSL_ASSERT_NEXT(a_accept_fills_s1, hsl.valid && hsl.ready, vld[1],
		"accepted transaction did not reach stage 1")
	`HSL_ASSERT_NOW(a_stall_only_when_full, !hsl.ready, &vld,
		"input stalled while a pipeline stage is empty")
	`HSL_ASSERT_NOW(a_m1_slope_range, vld[4], m1_s4 <= W1'(ONE) && d_s4 <= W1'(ONE),
		"m1 or slope out of range")
	`HSL_ASSERT_NOW(a_out_range, rgb.valid,
		rgb.red <= W1'(ONE) && rgb.green <= W1'(ONE) && rgb.blue <= W1'(ONE),
		"output channel above one")

endmodule

`default_nettype wire

// ===== tb/hsl_rgb_checker.sv =====
// Checker for the HSL to RGB converter: watches both channels, predicts each colour.
// Depends on hsl_pkg, hsl_in_if and hsl_out_if; instantiated beside the block by tb_top.
`default_nettype none

module hsl_rgb_checker (
	input  wire       clk,
	input  wire       arst_n,
	hsl_in_if         hsl,
	hsl_out_if        rgb,
	output int        mismatches,
	output int        awaiting
);

	localparam int FB = hsl_pkg::FRAC_BITS_DEF;
	localparam int CW = FB + 1;
	localparam longint unsigned ONE   = 64'd1 << FB;
	localparam longint unsigned TURN  = ONE - 1;
	localparam longint unsigned THIRD = ONE / 3;

	typedef struct packed {
		logic [FB:0] red;
		logic [FB:0] green;
		logic [FB:0] blue;
	} rgb_t;

	rgb_t colour_q[$];

	function automatic longint unsigned clamp_unit(longint unsigned v);
		return (v > ONE) ? ONE : v;
	endfunction

	// Piecewise-linear hue curve between the low and high levels
	function automatic logic [FB:0] curve_level(longint unsigned lo, longint unsigned hi,
		longint unsigned pos);
		longint unsigned span;
		longint unsigned v;
		span = hi - lo;
		if (6 * pos < ONE)
			v = lo + ((span * (6 * pos)) >> FB);
		else if (2 * pos < ONE)
			v = hi;
		else if (3 * pos < 2 * ONE)
			v = lo + ((span * (4 * ONE - 6 * pos)) >> FB);
		else
			v = lo;
		return CW'(clamp_unit(v));
	endfunction

	function automatic rgb_t rgb_of(logic [FB-1:0] hue, logic [FB:0] lig_in,
		logic [FB:0] sat_in);
		longint unsigned h;
		longint unsigned lig;
		longint unsigned sat;
		longint unsigned prod;
		longint unsigned hi;
		longint unsigned lo;
		rgb_t c;
		h   = 64'(hue);
		lig = clamp_unit(64'(lig_in));
		sat = clamp_unit(64'(sat_in));
		if (sat == 0) begin
			c.red   = CW'(lig);
			c.green = CW'(lig);
			c.blue  = CW'(lig);
			return c;
		end
		prod = (lig * sat) >> FB;
		if (2 * lig <= ONE)
			hi = lig + prod;
		else
			hi = lig + sat - prod;
		hi = clamp_unit(hi);
		if (hi > 2 * lig)
			hi = 2 * lig;
		lo = 2 * lig - hi;
		c.red   = curve_level(lo, hi, (h + THIRD) & TURN);
		c.green = curve_level(lo, hi, h);
		c.blue  = curve_level(lo, hi, (h + ONE - THIRD) & TURN);
		return c;
	endfunction

	task automatic report_mismatch(string what);
		$display("%0t rgb: %s", $time, what);
		mismatches++;
	endtask

	task automatic check_field(string name, logic [FB:0] got, logic [FB:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d, predicted %0d", name, got, want));
	endtask

	initial begin
		mismatches = 0;
		awaiting   = 0;
	end

	always @(posedge clk) begin
		rgb_t want;
		if (arst_n) begin
			if (hsl.valid && hsl.ready)
				colour_q.push_back(rgb_of(hsl.hue, hsl.lightness, hsl.saturation));
			if (rgb.valid && rgb.ready) begin
				if (colour_q.size() == 0) begin
					report_mismatch($sformatf("unexpected transaction %0d/%0d/%0d",
						rgb.red, rgb.green, rgb.blue));
				end else begin
					want = colour_q.pop_front();
					check_field("red", rgb.red, want.red);
					check_field("green", rgb.green, want.green);
					check_field("blue", rgb.blue, want.blue);
				end
			end
			awaiting <= colour_q.size();
		end
	end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Top of the HSL to RGB converter testbench: clock, reset, stimulus and verdict.
// Depends on hsl_pkg, hsl_in_if, hsl_out_if, hsl_to_rgb_convert and hsl_rgb_checker.
`default_nettype none

module tb_top;

	localparam int FB          = hsl_pkg::FRAC_BITS_DEF;
	localparam int LW          = FB + 1;
	localparam int ONE         = 1 << FB;
	localparam int RANDOM_CNT  = 1800;
	localparam int CALM_CNT    = 150;
	localparam int DRAIN_WAIT  = 12;
	localparam int CYCLE_LIMIT = 300000;

	logic clk;
	logic arst_n;
	logic calm;
	int   mismatches;
	int   awaiting;
	int   cycles;

	hsl_in_if  hsl_ch ();
	hsl_out_if rgb_ch ();

	hsl_to_rgb_convert DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.hsl    (hsl_ch),
		.rgb    (rgb_ch)
	);

	hsl_rgb_checker colour_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.hsl        (hsl_ch),
		.rgb        (rgb_ch),
		.mismatches (mismatches),
		.awaiting   (awaiting)
	);

	initial begin
		clk = 1'b0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: drop the run if the pipeline never drains
	initial begin
		cycles = 0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Pick a lightness or saturation level: mostly in range, some extremes, some
	// values above 1.0 that the block must clamp
	function automatic logic [FB:0] pick_level();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 5))
					0: return LW'(0);
					1: return LW'(1);
					2: return LW'(ONE / 2);
					3: return LW'(ONE / 2 + 1);
					4: return LW'(ONE - 1);
					default: return LW'(ONE);
				endcase
			end
			1: return LW'($urandom_range(ONE + 1, 2 * ONE - 1));
			default: return LW'($urandom_range(0, ONE));
		endcase
	endfunction

	// Offer one colour; hold valid until the transaction is taken
	task automatic send_colour(logic [FB-1:0] hue, logic [FB:0] lig, logic [FB:0] sat);
		if (!calm && $urandom_range(0, 4) == 0) begin
			repeat ($urandom_range(1, 7)) begin
				@(negedge clk);
				hsl_ch.valid <= 1'b0;
			end
		end
		@(negedge clk);
		hsl_ch.valid      <= 1'b1;
		hsl_ch.hue        <= hue;
		hsl_ch.lightness  <= lig;
		hsl_ch.saturation <= sat;
		do
			@(posedge clk);
		while (!hsl_ch.ready);
	endtask

	// Receiver: runs of ready broken by stall bursts, none once calm
	initial begin
		rgb_ch.ready = 1'b0;
		forever begin
			if (calm || $urandom_range(0, 3) != 0) begin
				repeat ($urandom_range(1, 40)) begin
					@(negedge clk);
					rgb_ch.ready <= 1'b1;
				end
			end else begin
				repeat ($urandom_range(1, 7)) begin
					@(negedge clk);
					rgb_ch.ready <= 1'b0;
				end
			end
		end
	end

	initial begin
		logic [FB-1:0] hue;
		hsl_ch.valid      = 1'b0;
		hsl_ch.hue        = '0;
		hsl_ch.lightness  = '0;
		hsl_ch.saturation = '0;
		calm   = 1'b0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: grey, pure hues, every segment edge of the hue curve, both
		// branches of the m2 formula, and clamping of over-range levels
		send_colour(0, 0, 0);
		send_colour(ONE - 1, ONE, ONE);
		send_colour(0, ONE, 0);
		send_colour(1000, ONE / 2, 0);
		send_colour(0, ONE / 2, ONE);
		send_colour(ONE / 3, ONE / 2, ONE);
		send_colour(2 * (ONE / 3), ONE / 2, ONE);
		send_colour(682, ONE / 2, ONE);
		send_colour(683, ONE / 2, ONE);
		send_colour(ONE / 2 - 1, ONE / 2, ONE);
		send_colour(ONE / 2, ONE / 2, ONE);
		send_colour(2730, ONE / 2, ONE);
		send_colour(2731, ONE / 2, ONE);
		send_colour(100, ONE / 2, 3000);
		send_colour(100, ONE / 2 + 1, 3000);
		send_colour(500, 2 * ONE - 1, 2 * ONE - 1);
		send_colour(3000, 5000, 1);
		send_colour(ONE - 1, 1, ONE);
		send_colour(2000, 3000, ONE + 1);
		send_colour(1, ONE, ONE);
		send_colour(1234, 2 * ONE - 1, 0);
		send_colour(3500, 1, 1);

		// Random colours; the tail runs with no idling on either side
		for (int n = 0; n < RANDOM_CNT; n++) begin
			if (n == RANDOM_CNT - CALM_CNT)
				calm = 1'b1;
			if ($urandom_range(0, 7) == 0)
				hue = FB'(($urandom_range(0, 5) * (ONE / 6)) + $urandom_range(0, 2) - 1);
			else
				hue = FB'($urandom_range(0, ONE - 1));
			send_colour(hue, pick_level(), pick_level());
		end
		@(negedge clk);
		hsl_ch.valid <= 1'b0;

		// Drain: wait for every predicted colour, then wait out DRAIN_WAIT before the verdict
		while (awaiting != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire
